// ----- rtl/core/bfr_pkg.sv -----
// Package for the barcode frame receiver: sizes, byte codes, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package bfr_pkg;

    // Sizing
    localparam int FRAME_BYTES   = 64;
    localparam int BARCODE_CHARS = 32;
    localparam int CNT_W         = $clog2(FRAME_BYTES);
    localparam int BC_AW         = (BARCODE_CHARS > 1) ? $clog2(BARCODE_CHARS) : 1;
    localparam int LEN_W         = $clog2(BARCODE_CHARS + 1);
    localparam int BC_DEPTH      = 2 ** (BC_AW + 1);
    localparam int TICK_W        = 16;
    localparam int CHAR_W        = 7;
    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    // Frame byte codes
    localparam logic [BYTE_W-1:0] BYTE_STX      = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_PRINT_LO = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_PRINT_HI = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_CR       = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_LF       = 8'h0A;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_WINDOW  = 2'd2;

    localparam logic              RST_OUTPUT_ENABLE = 1'b1;
    localparam logic [TICK_W-1:0] RST_FRAME_TIMEOUT = 16'd20;
    localparam logic [TICK_W-1:0] RST_GROUP_WINDOW  = 16'd500;

    localparam logic [TICK_W-1:0] TICK_MAX = 16'hFFFF;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_BYTE         = 2'd0,
        OP_TICK         = 2'd1,
        OP_READ_CONSUME = 2'd2,
        OP_READ_LATEST  = 2'd3
    } t_op;

    // Result kinds
    localparam logic KIND_PRINT = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_GATHER = 5'b00010,
        S_CHECK  = 5'b00100,
        S_EMIT   = 5'b01000,
        S_NONE   = 5'b10000
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear_idle;
        logic byte_wr;
        logic tick;
        logic parse_start;
        logic gather;
        logic restart_b;
        logic parse_finish;
        logic fill;
        logic mark_printed;
        logic consume;
        logic emit_start;
        logic emit_kind;
        logic load_char;
        logic load_none;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_eol;
        logic count_nz;
        logic frame_full;
        logic tmo_hit;
        logic print_hit;
        logic print_en;
        logic valid;
        logic consumed;
        logic out_free;
        logic gather_done;
        logic phase_a;
        logic n_zero;
        logic emit_last;
    } t_status;

endpackage

`default_nettype wire

// ----- rtl/core/bfr_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module bfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and register the read word (held while no read is issued)
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/bfr_ctrl.sv -----
// Controller state machine of the barcode frame receiver: sequences byte
// writes, frame parsing passes, print checks and result runs. Uses bfr_pkg.
`default_nettype none

module bfr_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bfr_pkg::t_op      i_op,
    input  bfr_pkg::t_status  i_status,
    output bfr_pkg::t_cmd     o_cmd
);

    import bfr_pkg::*;

    t_state r_state, n_state;
    logic   r_after_tick, n_after_tick;
    logic   r_after_fill, n_after_fill;
    logic   in_acc;

    // Take a new beat only between items
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state      = r_state;
        n_after_tick = r_after_tick;
        n_after_fill = r_after_fill;
        o_cmd        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_op)
                        OP_BYTE: begin
                            o_cmd.clear_idle = 1'b1;
                            if (i_status.is_eol) begin
                                if (i_status.count_nz) begin
                                    o_cmd.parse_start = 1'b1;
                                    n_after_tick      = 1'b0;
                                    n_after_fill      = 1'b0;
                                    n_state           = S_GATHER;
                                end
                            end else if (!i_status.frame_full) begin
                                o_cmd.byte_wr = 1'b1;
                            end else begin
                                // full frame: parse, then keep this byte as the first
                                o_cmd.parse_start = 1'b1;
                                n_after_tick      = 1'b0;
                                n_after_fill      = 1'b1;
                                n_state           = S_GATHER;
                            end
                        end
                        OP_TICK: begin
                            o_cmd.tick = 1'b1;
                            if (i_status.tmo_hit) begin
                                o_cmd.parse_start = 1'b1;
                                n_after_tick      = 1'b1;
                                n_after_fill      = 1'b0;
                                n_state           = S_GATHER;
                            end else begin
                                n_state = S_CHECK;
                            end
                        end
                        OP_READ_CONSUME: begin
                            if (i_status.valid && !i_status.consumed) begin
                                o_cmd.consume    = 1'b1;
                                o_cmd.emit_start = 1'b1;
                                o_cmd.emit_kind  = KIND_READ;
                                n_state          = S_EMIT;
                            end else begin
                                n_state = S_NONE;
                            end
                        end
                        OP_READ_LATEST: begin
                            if (i_status.valid) begin
                                o_cmd.emit_start = 1'b1;
                                o_cmd.emit_kind  = KIND_READ;
                                n_state          = S_EMIT;
                            end else begin
                                n_state = S_NONE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_GATHER: begin
                o_cmd.gather = 1'b1;
                if (i_status.gather_done) begin
                    if (i_status.phase_a && i_status.n_zero) begin
                        // data field gave nothing: fall back to the whole frame
                        o_cmd.restart_b = 1'b1;
                    end else begin
                        o_cmd.parse_finish = 1'b1;
                        o_cmd.fill         = r_after_fill;
                        n_state            = r_after_tick ? S_CHECK : S_IDLE;
                    end
                end
            end
            S_CHECK: begin
                n_state = S_IDLE;
                if (i_status.print_hit) begin
                    o_cmd.mark_printed = 1'b1;
                    if (i_status.print_en) begin
                        o_cmd.emit_start = 1'b1;
                        o_cmd.emit_kind  = KIND_PRINT;
                        n_state          = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.load_char = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_NONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_none = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_after_tick <= 1'b0;
            r_after_fill <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_after_tick <= n_after_tick;
            r_after_fill <= n_after_fill;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/bfr_datapath.sv -----
// Datapath of the barcode frame receiver: frame store, header capture, gather
// pass, banked barcode store, timers, configuration and output register.
// Uses bfr_pkg and bfr_ram.
`default_nettype none

module bfr_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [bfr_pkg::BYTE_W-1:0]      i_data_byte,
    input  logic                            i_cfg_valid,
    input  logic [bfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bfr_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    output logic                            o_kind,
    output logic                            o_found,
    output logic [bfr_pkg::CHAR_W-1:0]      o_character,
    output logic                            o_last,
    input  bfr_pkg::t_cmd                   i_cmd,
    output bfr_pkg::t_status                o_status
);

    import bfr_pkg::*;

    // Control state
    logic [CNT_W-1:0]  r_count;
    logic [TICK_W-1:0] r_idle;
    logic [TICK_W-1:0] r_age;
    logic [LEN_W-1:0]  r_len;
    logic [LEN_W-1:0]  r_n;
    logic              r_valid;
    logic              r_consumed;
    logic              r_printed;
    logic              r_bank;
    logic              r_dv;
    logic              r_out_valid;
    logic              r_out_en;
    logic [TICK_W-1:0] r_tmo;
    logic [TICK_W-1:0] r_win;

    // Payload state
    logic [BYTE_W-1:0] r_hdr0, r_hdr1, r_hdr2;
    logic [BYTE_W-1:0] r_pend;
    logic [CNT_W-1:0]  r_rd_addr;
    logic [CNT_W-1:0]  r_rd_end;
    logic              r_phase_a;
    logic [LEN_W-1:0]  r_emit_idx;
    logic              r_emit_kind;
    logic              r_out_kind;
    logic              r_out_found;
    logic [CHAR_W-1:0] r_out_char;
    logic              r_out_last;

    logic [TICK_W-1:0] idle_inc;
    logic [TICK_W-1:0] age_inc;
    logic [BYTE_W:0]   data_end;
    logic              hdr_ok;
    logic              issue;
    logic              printable;
    logic              gwr;
    logic              out_free;
    logic [LEN_W-1:0]  emit_next;
    logic              emit_last;

    logic              fr_we;
    logic [CNT_W-1:0]  fr_waddr;
    logic [BYTE_W-1:0] fr_wdata;
    logic [BYTE_W-1:0] fr_rdata;
    logic              bc_re;
    logic [BC_AW:0]    bc_raddr;
    logic [CHAR_W-1:0] bc_rdata;

    // Saturating timer increments
    assign idle_inc = (r_idle == TICK_MAX) ? r_idle : r_idle + TICK_W'(1);
    assign age_inc  = (r_age == TICK_MAX) ? r_age : r_age + TICK_W'(1);

    // Header check: STX, zero, nonzero length, all data bytes present
    assign data_end = {1'b0, r_hdr2} + (BYTE_W + 1)'(3);
    assign hdr_ok   = (r_count >= CNT_W'(4)) && (r_hdr0 == BYTE_STX)
                      && (r_hdr1 == BYTE_ZERO) && (r_hdr2 != BYTE_ZERO)
                      && (data_end <= (BYTE_W + 1)'(r_count));

    // Gather pass: one frame read a cycle, filter on the registered word
    assign issue     = i_cmd.gather && (r_rd_addr < r_rd_end);
    assign printable = (fr_rdata >= BYTE_PRINT_LO) && (fr_rdata <= BYTE_PRINT_HI);
    assign gwr       = r_dv && printable && (r_n < LEN_W'(BARCODE_CHARS));

    assign fr_we    = i_cmd.byte_wr || (i_cmd.parse_finish && i_cmd.fill);
    assign fr_waddr = i_cmd.byte_wr ? r_count : '0;
    assign fr_wdata = i_cmd.byte_wr ? i_data_byte : r_pend;

    bfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_BYTES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (fr_waddr),
        .i_wdata (fr_wdata),
        .i_re    (issue),
        .i_raddr (r_rd_addr),
        .o_rdata (fr_rdata)
    );

    // Barcode store: new result fills the inactive bank, swap on success
    assign emit_next = r_emit_idx + LEN_W'(1);
    assign emit_last = (emit_next == r_len);
    assign bc_re     = i_cmd.emit_start || i_cmd.load_char;
    assign bc_raddr  = i_cmd.emit_start ? {r_bank, BC_AW'(0)}
                                        : {r_bank, emit_next[BC_AW-1:0]};

    bfr_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BC_DEPTH)
    ) u_barcode_ram (
        .i_clk   (i_clk),
        .i_we    (gwr),
        .i_waddr ({~r_bank, r_n[BC_AW-1:0]}),
        .i_wdata (fr_rdata[CHAR_W-1:0]),
        .i_re    (bc_re),
        .i_raddr (bc_raddr),
        .o_rdata (bc_rdata)
    );

    assign out_free = !r_out_valid || !i_out_stall;

    // Status to the controller
    always_comb begin
        o_status.is_eol      = (i_data_byte == BYTE_CR) || (i_data_byte == BYTE_LF);
        o_status.count_nz    = (r_count != '0);
        o_status.frame_full  = (r_count == CNT_W'(FRAME_BYTES - 1));
        o_status.tmo_hit     = (r_count != '0) && (idle_inc >= r_tmo);
        o_status.print_hit   = r_valid && !r_printed && (r_age >= r_win);
        o_status.print_en    = r_out_en;
        o_status.valid       = r_valid;
        o_status.consumed    = r_consumed;
        o_status.out_free    = out_free;
        o_status.gather_done = !issue && !r_dv;
        o_status.phase_a     = r_phase_a;
        o_status.n_zero      = (r_n == '0);
        o_status.emit_last   = emit_last;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idle      <= '0;
            r_age       <= '0;
            r_len       <= '0;
            r_n         <= '0;
            r_valid     <= 1'b0;
            r_consumed  <= 1'b0;
            r_printed   <= 1'b0;
            r_bank      <= 1'b0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_en    <= RST_OUTPUT_ENABLE;
            r_tmo       <= RST_FRAME_TIMEOUT;
            r_win       <= RST_GROUP_WINDOW;
        end else begin
            r_dv <= issue;

            // configuration writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_OUTPUT_ENABLE: r_out_en <= i_cfg_data[0];
                    CFG_FRAME_TIMEOUT: r_tmo    <= i_cfg_data;
                    CFG_GROUP_WINDOW:  r_win    <= i_cfg_data;
                    default:           r_out_en <= r_out_en;
                endcase
            end

            // timers
            if (i_cmd.clear_idle) begin
                r_idle <= '0;
            end
            if (i_cmd.tick) begin
                r_idle <= idle_inc;
                r_age  <= age_inc;
            end

            // frame fill
            if (i_cmd.byte_wr) begin
                r_count <= r_count + CNT_W'(1);
            end

            // gathered character count
            if (i_cmd.parse_start || i_cmd.restart_b) begin
                r_n <= '0;
            end else if (gwr) begin
                r_n <= r_n + LEN_W'(1);
            end

            // close the parse: empty the frame, install a non-empty barcode
            if (i_cmd.parse_finish) begin
                r_count <= i_cmd.fill ? CNT_W'(1) : '0;
                r_idle  <= '0;
                if (r_n != '0) begin
                    r_bank     <= ~r_bank;
                    r_len      <= r_n;
                    r_valid    <= 1'b1;
                    r_consumed <= 1'b0;
                    r_printed  <= 1'b0;
                    r_age      <= '0;
                end
            end

            if (i_cmd.mark_printed) begin
                r_printed <= 1'b1;
            end
            if (i_cmd.consume) begin
                r_consumed <= 1'b1;
            end

            // output register
            if (i_cmd.load_char || i_cmd.load_none) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.byte_wr) begin
            if (r_count == CNT_W'(0)) begin
                r_hdr0 <= i_data_byte;
            end
            if (r_count == CNT_W'(1)) begin
                r_hdr1 <= i_data_byte;
            end
            if (r_count == CNT_W'(2)) begin
                r_hdr2 <= i_data_byte;
            end
        end
        if (i_cmd.parse_finish && i_cmd.fill) begin
            r_hdr0 <= r_pend;
        end

        if (i_cmd.parse_start) begin
            r_pend    <= i_data_byte;
            r_phase_a <= hdr_ok;
            r_rd_addr <= hdr_ok ? CNT_W'(3) : '0;
            r_rd_end  <= hdr_ok ? CNT_W'(data_end) : r_count;
        end else if (i_cmd.restart_b) begin
            r_phase_a <= 1'b0;
            r_rd_addr <= '0;
            r_rd_end  <= r_count;
        end else if (issue) begin
            r_rd_addr <= r_rd_addr + CNT_W'(1);
        end

        if (i_cmd.emit_start) begin
            r_emit_idx  <= '0;
            r_emit_kind <= i_cmd.emit_kind;
        end else if (i_cmd.load_char) begin
            r_emit_idx <= emit_next;
        end

        if (i_cmd.load_char) begin
            r_out_kind  <= r_emit_kind;
            r_out_found <= 1'b1;
            r_out_char  <= bc_rdata;
            r_out_last  <= emit_last;
        end else if (i_cmd.load_none) begin
            r_out_kind  <= KIND_READ;
            r_out_found <= 1'b0;
            r_out_char  <= '0;
            r_out_last  <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_found     = r_out_found;
    assign o_character = r_out_char;
    assign o_last      = r_out_last;

    // Checks
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_char || i_cmd.load_none) |-> out_free)
        else $error("result loaded over a stalled beat");

    a_gather_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= LEN_W'(BARCODE_CHARS))
        else $error("gathered count beyond barcode limit");

    a_frame_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FRAME_BYTES - 1))
        else $error("frame count beyond store depth");

    a_valid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_len != '0))
        else $error("valid barcode with zero length");

    a_parse_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.parse_finish |=> (r_count <= CNT_W'(1)) && (r_idle == '0))
        else $error("parse did not empty the frame");

endmodule

`default_nettype wire

// ----- rtl/core/barcode_frame_receiver_top.sv -----
// Top level of the barcode frame receiver: controller, datapath and
// configuration port. Uses bfr_pkg, bfr_ctrl and bfr_datapath.
//
// Usage
//   Input channel (i_in_valid / o_in_stall): one beat carries an operation
//   (received byte, millisecond tick, consuming read, plain read) and a byte.
//   Output channel (o_out_valid / i_out_stall): one beat per barcode character
//   with kind, found, character and last; a read with nothing to return gives
//   a single beat with found low and last high.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready): index 0 output
//   enable, 1 frame timeout, 2 group window; other indexes are ignored.
// Passes
//   A parse walks the frame store at one byte a cycle through its single read
//   port, and makes a second pass over the whole frame when the data field
//   yields nothing. A result run gives one character per cycle while the
//   output is not stalled, up to the barcode limit.
// Reset and stall
//   Synchronous active-low reset empties the frame, drops any barcode and
//   restores register defaults; no clearing pass is needed. When the receiver
//   stalls, the run pauses with its beat held, and o_in_stall stays high until
//   the last beat of the run sits in the output register.
`default_nettype none

module barcode_frame_receiver_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [1:0]                      i_operation,
    input  logic [bfr_pkg::BYTE_W-1:0]      i_data_byte,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_kind,
    output logic                            o_found,
    output logic [bfr_pkg::CHAR_W-1:0]      o_character,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import bfr_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Configuration writes are always taken
    assign o_cfg_ready = 1'b1;

    bfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_op       (t_op'(i_operation)),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bfr_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_data_byte),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_kind      (o_kind),
        .o_found     (o_found),
        .o_character (o_character),
        .o_last      (o_last),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

`default_nettype wire
